// ===== rtl/core/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 step of the sensor frame decoder.
`default_nettype none

package htfd_pkg;

  // Byte slot within the six-byte reply, one-hot.
  typedef enum logic [5:0] {
    ST_T_HI  = 6'b000001,
    ST_T_LO  = 6'b000010,
    ST_T_CRC = 6'b000100,
    ST_H_HI  = 6'b001000,
    ST_H_LO  = 6'b010000,
    ST_H_CRC = 6'b100000
  } state_t;

  // One complete reply, as handed from the front end to the back end.
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;
    logic        hum_crc_ok;
  } frame_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scale factors: value = offset + (scale * raw) >> 16
  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE  = 14'd10000;

  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
  localparam logic signed [15:0] TEMP_LOW    = -16'sd4000;
  localparam logic signed [15:0] TEMP_HIGH   = 16'sd12500;
  localparam logic [13:0]        HUM_MAX     = 14'd10000;

  // MSB-first CRC-8 over one byte, no reflection, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htfd_front.sv =====
// Front end: tracks the byte slot, runs the CRC and assembles complete replies.
`default_nettype none

module htfd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            frame_start,
  output logic                 push,
  output htfd_pkg::frame_t     push_frame
);

  htfd_pkg::state_t state_r, state_nxt, slot;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [7:0]  hum_hi_r, hum_hi_nxt;
  logic [7:0]  hum_lo_r, hum_lo_nxt;
  logic        temp_ok_r, temp_ok_nxt;

  assign slot = frame_start ? htfd_pkg::ST_T_HI : state_r;

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_hi_nxt    = hum_hi_r;
    hum_lo_nxt    = hum_lo_r;
    temp_ok_nxt   = temp_ok_r;
    push          = 1'b0;
    push_frame.temp_word   = temp_word_r;
    push_frame.hum_word    = {hum_hi_r, hum_lo_r};
    push_frame.temp_crc_ok = temp_ok_r;
    push_frame.hum_crc_ok  = (crc_r == data_byte);
    if (byte_fire) begin
      case (slot)
        htfd_pkg::ST_T_LO: begin
          crc_nxt       = htfd_pkg::crc8_update(crc_r, data_byte);
          temp_word_nxt = {temp_word_r[15:8], data_byte};
          state_nxt     = htfd_pkg::ST_T_CRC;
        end
        htfd_pkg::ST_T_CRC: begin
          temp_ok_nxt = (crc_r == data_byte);
          crc_nxt     = htfd_pkg::CRC_INIT;
          state_nxt   = htfd_pkg::ST_H_HI;
        end
        htfd_pkg::ST_H_HI: begin
          crc_nxt    = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, data_byte);
          hum_hi_nxt = data_byte;
          state_nxt  = htfd_pkg::ST_H_LO;
        end
        htfd_pkg::ST_H_LO: begin
          crc_nxt    = htfd_pkg::crc8_update(crc_r, data_byte);
          hum_lo_nxt = data_byte;
          state_nxt  = htfd_pkg::ST_H_CRC;
        end
        htfd_pkg::ST_H_CRC: begin
          push      = 1'b1;
          crc_nxt   = htfd_pkg::CRC_INIT;
          state_nxt = htfd_pkg::ST_T_HI;
        end
        default: begin
          // first byte of a reply (also any stray code)
          crc_nxt       = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, data_byte);
          temp_word_nxt = {data_byte, temp_word_r[7:0]};
          state_nxt     = htfd_pkg::ST_T_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htfd_pkg::ST_T_HI;
      crc_r       <= htfd_pkg::CRC_INIT;
      temp_word_r <= '0;
      hum_hi_r    <= '0;
      hum_lo_r    <= '0;
      temp_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_hi_r    <= hum_hi_nxt;
      hum_lo_r    <= hum_lo_nxt;
      temp_ok_r   <= temp_ok_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/htfd_queue.sv =====
// Short queue of complete replies between the front and back ends.
`default_nettype none

module htfd_queue #(
  parameter int unsigned Depth = htfd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire htfd_pkg::frame_t push_frame,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output htfd_pkg::frame_t      head_frame
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  htfd_pkg::frame_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_frame = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/htfd_back.sv =====
// Back end: scales the raw words, checks range and holds the result for the consumer.
`default_nettype none

module htfd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire htfd_pkg::frame_t head_frame,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic signed [14:0]    out_temperature_centi,
  output logic [13:0]           out_humidity_centi,
  output logic                  out_temp_crc_ok,
  output logic                  out_hum_crc_ok,
  output logic                  out_in_range,
  output logic                  out_reading_valid
);

  // Stage 1: scaling products
  logic        s1_valid_r, s1_valid_nxt;
  logic [14:0] s1_temp_q_r;
  logic [13:0] s1_hum_q_r;
  logic        s1_tok_r, s1_hok_r;
  logic [30:0] prod_t;
  logic [29:0] prod_h;

  // Stage 2: result register
  logic        out_valid_r, out_valid_nxt;
  logic signed [15:0] temp_full;
  logic        rng;

  logic out_adv, s1_adv;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign pop     = s1_adv;

  assign prod_t = 31'(htfd_pkg::TEMP_SCALE) * 31'(head_frame.temp_word);
  assign prod_h = 30'(htfd_pkg::HUM_SCALE) * 30'(head_frame.hum_word);

  assign s1_valid_nxt  = s1_adv ? head_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  assign temp_full = $signed({1'b0, s1_temp_q_r}) + htfd_pkg::TEMP_OFFSET;
  assign rng = (temp_full > htfd_pkg::TEMP_LOW) && (temp_full < htfd_pkg::TEMP_HIGH) &&
               (s1_hum_q_r <= htfd_pkg::HUM_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_temp_q_r <= prod_t[30:16];
      s1_hum_q_r  <= prod_h[29:16];
      s1_tok_r    <= head_frame.temp_crc_ok;
      s1_hok_r    <= head_frame.hum_crc_ok;
    end
    if (out_adv) begin
      out_temperature_centi <= temp_full[14:0];
      out_humidity_centi    <= s1_hum_q_r;
      out_temp_crc_ok       <= s1_tok_r;
      out_hum_crc_ok        <= s1_hok_r;
      out_in_range          <= rng;
      out_reading_valid     <= s1_tok_r && s1_hok_r && rng;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
// Top level of the temperature/humidity sensor reply decoder.
//
// Decodes the six-byte reply of a temperature/humidity sensor, one byte per
// request: temperature high, temperature low, temperature CRC, humidity high,
// humidity low, humidity CRC. Each CRC-8 (polynomial 0x31, init 0xFF, MSB
// first) covers the two bytes of its word. The sixth byte of a reply yields
// one result request carrying temperature in hundredths of a degree
// (-4500 + (17500*raw) >> 16), humidity in hundredths of a percent
// ((10000*raw) >> 16), both CRC flags, a range flag (temperature strictly
// between -40.00 and 125.00, humidity at most 100.00) and an overall valid
// flag; the result is still delivered when a CRC fails. in_frame_start
// forces its byte to be taken as the first of a new reply and drops any
// partial one; after the sixth byte the slot wraps, so consecutive replies
// need no marker. One byte is taken every cycle while the queue has room:
// the front end (slot tracking, CRC) updates its registers as each byte is
// taken, and a completed reply waits in a queue of QueueDepth entries before
// a two-stage back end (constant multiply into the stage-1 registers, then
// offset and range check into the output register). in_ready drops only while
// the queue is full, which happens only when the consumer holds out_ready low.
`default_nettype none

module humidity_temp_frame_decoder #(
  parameter int unsigned QueueDepth = htfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_start,
  // result requests
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]      out_humidity_centi,
  output logic             out_temp_crc_ok,
  output logic             out_hum_crc_ok,
  output logic             out_in_range,
  output logic             out_reading_valid
);

  logic             byte_fire;
  logic             push;
  htfd_pkg::frame_t push_frame;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  htfd_pkg::frame_t head_frame;

  // Hold off bytes only while no room is left for a finished reply.
  assign in_ready  = !q_full;
  assign byte_fire = in_valid && in_ready;

  htfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (byte_fire),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .push_frame  (push_frame)
  );

  htfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  htfd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (head_valid),
    .head_frame            (head_frame),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_temp_crc_ok       (out_temp_crc_ok),
    .out_hum_crc_ok        (out_hum_crc_ok),
    .out_in_range          (out_in_range),
    .out_reading_valid     (out_reading_valid)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the sensor reply decoder: queued byte requests in, predicted readings out.
`timescale 1ns / 100ps

module tb;

  // Byte slots of one sensor reply, in arrival order.
  localparam logic [2:0] SLOT_T_HI  = 3'd0;
  localparam logic [2:0] SLOT_T_LO  = 3'd1;
  localparam logic [2:0] SLOT_T_CRC = 3'd2;
  localparam logic [2:0] SLOT_H_HI  = 3'd3;
  localparam logic [2:0] SLOT_H_LO  = 3'd4;
  localparam logic [2:0] SLOT_H_CRC = 3'd5;

  localparam logic [7:0]  CRC_SEED   = 8'hFF;
  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam int          T_OFFSET   = -4500;
  localparam int unsigned T_SCALE    = 17500;
  localparam int unsigned H_SCALE    = 10000;
  localparam int          T_FLOOR    = -4000;
  localparam int          T_CEIL     = 12500;
  localparam int unsigned H_CEIL     = 10000;

  localparam int N_BYTES     = 950;     // random part stops once the queue holds at least this many
  localparam int GAP_PERCENT = 19;      // chance of an idle cycle on either side
  localparam int QUIET_FROM  = 300;     // no idling at all inside this cycle window
  localparam int QUIET_TO    = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_req_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic               temp_ok;
    logic               hum_ok;
    logic               range_ok;
    logic               valid;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_frame_start = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] out_temperature_centi;
  logic [13:0]        out_humidity_centi;
  logic               out_temp_crc_ok;
  logic               out_hum_crc_ok;
  logic               out_in_range;
  logic               out_reading_valid;

  byte_req_t pending_bytes[$];   // byte requests not yet offered to the block
  reading_t  due_readings[$];    // readings predicted but not yet seen on the output

  int errors = 0;
  int cycle_count = 0;

  // Decoder state as tracked by the bench.
  logic [2:0]  slot_q     = SLOT_T_HI;
  logic [7:0]  crc_q      = CRC_SEED;
  logic [15:0] tword_q    = 16'h0000;
  logic [7:0]  hum_hi_q   = 8'h00;
  logic [7:0]  hum_lo_q   = 8'h00;
  logic        tmatch_q   = 1'b0;

  humidity_temp_frame_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_temp_crc_ok       (out_temp_crc_ok),
    .out_hum_crc_ok        (out_hum_crc_ok),
    .out_in_range          (out_in_range),
    .out_reading_valid     (out_reading_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // CRC-8, MSB first: fold the byte in one bit at a time against the register top bit.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Idle decision shared by both sides; the quiet window gives a long run at full rate.
  function automatic bit take_gap();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < GAP_PERCENT;
  endfunction

  // Advance the tracked state by one accepted byte; queue a reading after the sixth.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]  slot;
    logic [15:0] raw_h;
    int unsigned t_prod;
    int unsigned h_val;
    int          t_val;
    reading_t    r;
    slot = (start || slot_q > SLOT_H_CRC) ? SLOT_T_HI : slot_q;
    case (slot)
      SLOT_T_HI: begin
        crc_q         = crc8_step(CRC_SEED, b);
        tword_q[15:8] = b;
      end
      SLOT_T_LO: begin
        crc_q        = crc8_step(crc_q, b);
        tword_q[7:0] = b;
      end
      SLOT_T_CRC: begin
        tmatch_q = (crc_q == b);
        crc_q    = CRC_SEED;
      end
      SLOT_H_HI: begin
        crc_q    = crc8_step(CRC_SEED, b);
        hum_hi_q = b;
      end
      SLOT_H_LO: begin
        crc_q    = crc8_step(crc_q, b);
        hum_lo_q = b;
      end
      default: begin
        // Scale both words, floor by the 16-bit shift, then judge range and CRCs.
        raw_h      = {hum_hi_q, hum_lo_q};
        t_prod     = T_SCALE * {16'd0, tword_q};
        t_val      = T_OFFSET + int'(t_prod >> 16);
        h_val      = (H_SCALE * {16'd0, raw_h}) >> 16;
        r.temp     = t_val[14:0];
        r.hum      = h_val[13:0];
        r.temp_ok  = tmatch_q;
        r.hum_ok   = (crc_q == b);
        r.range_ok = (t_val > T_FLOOR) && (t_val < T_CEIL) && (h_val <= H_CEIL);
        r.valid    = r.temp_ok && r.hum_ok && r.range_ok;
        due_readings.push_back(r);
        crc_q = CRC_SEED;
      end
    endcase
    slot_q = (slot == SLOT_H_CRC) ? SLOT_T_HI : slot + 3'd1;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    byte_req_t req;
    req.data  = b;
    req.start = start;
    pending_bytes.push_back(req);
  endtask

  // Queue a whole reply; a bad CRC is the good one with at least one bit flipped.
  task automatic push_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                            input bit t_good, input bit h_good, input logic start);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = crc8_step(crc8_step(CRC_SEED, raw_t[15:8]), raw_t[7:0]);
    h_crc = crc8_step(crc8_step(CRC_SEED, raw_h[15:8]), raw_h[7:0]);
    if (!t_good) begin
      t_crc = t_crc ^ 8'($urandom_range(1, 255));
    end
    if (!h_good) begin
      h_crc = h_crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(raw_t[15:8], start);
    push_byte(raw_t[7:0], 1'b0);
    push_byte(t_crc, 1'b0);
    push_byte(raw_h[15:8], 1'b0);
    push_byte(raw_h[7:0], 1'b0);
    push_byte(h_crc, 1'b0);
  endtask

  // Temperature words near the range edges and the extremes get extra weight.
  function automatic logic [15:0] pick_temp_word();
    logic [15:0] edges[8];
    edges = '{16'd0, 16'd1872, 16'd1873, 16'd1876, 16'd1877, 16'd63663, 16'd63664, 16'hFFFF};
    if ($urandom_range(99) < 25) begin
      return edges[3'($urandom_range(7))];
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_hum_word();
    if ($urandom_range(99) < 10) begin
      return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task check_field(input string name, input logic signed [31:0] want,
                   input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Driver: offer the next byte request when the channel is free, hold it until taken.
  always @(posedge clk) begin : byte_driver
    byte_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        // The block registers each reading in its queue and back end, so this push
        // lands well before the monitor can pop it.
        decode_byte(in_data_byte, in_frame_start);
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && !take_gap()) begin
          req = pending_bytes.pop_front();
          in_valid       <= 1'b1;
          in_data_byte   <= req.data;
          in_frame_start <= req.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take each result request and match it against the oldest predicted reading.
  always @(posedge clk) begin : reading_monitor
    reading_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_readings.size() == 0) begin
          $error("reading with no prediction outstanding: temperature %0d, humidity %0d",
                 out_temperature_centi, out_humidity_centi);
          errors++;
        end else begin
          want = due_readings.pop_front();
          check_field("temperature_centi", 32'(want.temp), 32'(out_temperature_centi));
          check_field("humidity_centi", 32'(want.hum), 32'(out_humidity_centi));
          check_field("temp_crc_ok", 32'(want.temp_ok), 32'(out_temp_crc_ok));
          check_field("hum_crc_ok", 32'(want.hum_ok), 32'(out_hum_crc_ok));
          check_field("in_range", 32'(want.range_ok), 32'(out_in_range));
          check_field("reading_valid", 32'(want.valid), 32'(out_reading_valid));
        end
      end
      out_ready <= !take_gap();
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    int drain;

    // Directed: all-zero reply (below range), all-ones reply with a bad
    // temperature CRC following on without a marker, a reply abandoned after
    // two bytes and restarted with a bad humidity CRC at exactly -40.00, and a
    // clean in-range reply just under the upper limit, again by wrap.
    push_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    push_byte(8'h66, 1'b1);
    push_byte(8'h66, 1'b0);
    push_frame(16'd1873, 16'h8000, 1'b1, 1'b0, 1'b1);
    push_frame(16'd63663, 16'h4000, 1'b1, 1'b1, 1'b0);

    // Random: mostly clean replies with random content, some cut short, some plain noise.
    while (pending_bytes.size() < N_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        push_frame(pick_temp_word(), pick_hum_word(), $urandom_range(99) < 80,
                   $urandom_range(99) < 80, $urandom_range(99) < 60);
      end else if (pick < 90) begin
        len = $urandom_range(1, 5);
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int k = 1; k < len; k++) begin
          push_byte(8'($urandom_range(255)), 1'b0);
        end
        push_frame(pick_temp_word(), pick_hum_word(), 1'b1, 1'b1, 1'b1);
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every byte request has been taken, then drain the readings.
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    drain = 0;
    while (due_readings.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    // Allow a few more cycles to catch any stray reading.
    repeat (10) @(posedge clk);

    if (due_readings.size() != 0) begin
      $error("%0d predicted readings never arrived", due_readings.size());
      errors++;
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
